FILE: hw/rtl/at_rlc_pkg.sv
// ----------------------------------------------------------------------------
// at_rlc_pkg
// Opcodes, event codes, keyword patterns and sizes for the response line
// classifier.
// ----------------------------------------------------------------------------
package at_rlc_pkg;

    localparam int LineMax    = 128;
    localparam int IpMax      = 32;
    localparam int QueueDepth = 8;
    localparam int WinLen     = 15;
    localparam int SubCount   = 11;

    localparam int LenW  = $clog2(LineMax);
    localparam int IpW   = $clog2(IpMax);
    localparam int QW    = $clog2(QueueDepth);

    typedef enum logic [2:0] {
        OP_CHAR  = 3'd0,
        OP_EOL   = 3'd1,
        OP_POP   = 3'd2,
        OP_SEND  = 3'd3,
        OP_IPRD  = 3'd4,
        OP_CLEAR = 3'd5
    } t_opcode;

    typedef logic [3:0] t_event;

    localparam t_event EV_NONE      = 4'd0;
    localparam t_event EV_GOT_IP    = 4'd1;
    localparam t_event EV_OK        = 4'd2;
    localparam t_event EV_ERROR     = 4'd3;
    localparam t_event EV_DISCONN   = 4'd4;
    localparam t_event EV_CONNECTED = 4'd5;
    localparam t_event EV_IP_PARSED = 4'd6;
    localparam t_event EV_TCP_CONN  = 4'd7;
    localparam t_event EV_TCP_CLOSE = 4'd8;
    localparam t_event EV_PROMPT    = 4'd9;
    localparam t_event EV_SEND_OK   = 4'd10;
    localparam t_event EV_SEND_FAIL = 4'd11;

    localparam int KW_GOT_IP  = 0;
    localparam int KW_ERROR   = 1;
    localparam int KW_FAIL    = 2;
    localparam int KW_DISCONN = 3;
    localparam int KW_BUSY    = 4;
    localparam int KW_CONN_ED = 5;
    localparam int KW_CIFSR   = 6;
    localparam int KW_CLOSED  = 7;
    localparam int KW_PROMPT  = 8;
    localparam int KW_SEND_OK = 9;
    localparam int KW_SEND_FL = 10;

    localparam logic [87:0]  PAT_GOT_IP  = "WIFI GOT IP";
    localparam logic [39:0]  PAT_ERROR   = "ERROR";
    localparam logic [31:0]  PAT_FAIL    = "FAIL";
    localparam logic [119:0] PAT_DISCONN = "WIFI DISCONNECT";
    localparam logic [31:0]  PAT_BUSY    = "busy";
    localparam logic [111:0] PAT_CONN_ED = "WIFI CONNECTED";
    localparam logic [95:0]  PAT_CIFSR   = "+CIFSR:STAIP";
    localparam logic [47:0]  PAT_CLOSED  = "CLOSED";
    localparam logic [7:0]   PAT_PROMPT  = ">";
    localparam logic [55:0]  PAT_SEND_OK = "SEND OK";
    localparam logic [71:0]  PAT_SEND_FL = "SEND FAIL";
    localparam logic [15:0]  PAT_OK      = "OK";
    localparam logic [55:0]  PAT_CONNECT = "CONNECT";
    localparam logic [7:0]   CHR_QUOTE   = 8'h22;

endpackage

FILE: hw/rtl/at_response_line_classifier.sv
// ----------------------------------------------------------------------------
// at_response_line_classifier
// Sorts modem response lines into event codes, queues them in a ring and
// keeps the last parsed IP address text.
// ----------------------------------------------------------------------------
//  channel  | valid   | stall   | payload
//  ---------+---------+---------+---------------------------------------------
//  input    | i_valid | o_stall | i_opcode, i_char_byte, i_ip_index
//  output   | o_valid | i_stall | o_event_code, o_busy_res, o_send_accepted,
//           |         |         | o_ip_char, o_ip_length, o_event_dropped
//
//  One beat in per cycle while o_stall is low; each result passes the read
//  stage and then the output register, after the registered read of the event ring and IP memories.
//  Synchronous reset clears line, ring pointers, IP length and busy flag.
//  A stalled output holds one result and one more in the read stage, then
//  the input stalls.
// ----------------------------------------------------------------------------
module at_response_line_classifier (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [2:0] i_opcode,
    input  logic [7:0] i_char_byte,
    input  logic [4:0] i_ip_index,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [3:0] o_event_code,
    output logic       o_busy_res,
    output logic       o_send_accepted,
    output logic [7:0] o_ip_char,
    output logic [4:0] o_ip_length,
    output logic       o_event_dropped
);

    localparam int WinW = at_rlc_pkg::WinLen * 8;
    localparam int LW   = at_rlc_pkg::LenW;
    localparam int IW   = at_rlc_pkg::IpW;
    localparam int QW   = at_rlc_pkg::QW;

    logic [7:0]                 r_ip_mem [2 * at_rlc_pkg::IpMax];
    at_rlc_pkg::t_event         r_ring   [at_rlc_pkg::QueueDepth];

    logic [WinW-1:0]            r_win, n_win;
    logic [LW-1:0]              r_len, n_len;
    logic [at_rlc_pkg::SubCount-1:0] r_flags, n_flags;
    logic [1:0]                 r_exact, n_exact;
    logic [LW-1:0]              r_fq, n_fq, r_lq, n_lq;
    logic                       r_fq_v, n_fq_v, r_lq_v, n_lq_v;
    logic                       r_bank, n_bank;
    logic [IW-1:0]              r_iplen, n_iplen;
    logic [QW-1:0]              r_head, n_head, r_tail, n_tail;
    logic                       r_wait, n_wait;

    logic                       r_s1_vld;
    logic                       r_s1_pop, r_s1_ipen, r_s1_acc, r_s1_drop, r_s1_wait;
    logic [IW-1:0]              r_s1_iplen;
    at_rlc_pkg::t_event         r_ev_rd;
    logic [7:0]                 r_ip_rd;

    logic                       r_o_vld;
    at_rlc_pkg::t_event         r_o_ev;
    logic                       r_o_wait, r_o_acc, r_o_drop;
    logic [7:0]                 r_o_ipc;
    logic [IW-1:0]              r_o_iplen;

    logic                       adv, acc;
    logic                       n_pop, n_ipen, n_acc, n_drop;
    logic                       cap_we, push_we;
    logic [IW-1:0]              cap_off;
    at_rlc_pkg::t_event         ev;
    logic [LW-1:0]              q_len;
    logic [LW-1:0]              gap;

    assign adv     = !r_o_vld || !i_stall;
    assign o_stall = r_s1_vld && !adv;
    assign acc     = i_valid && !o_stall;

    always_comb begin
        n_win   = r_win;
        n_len   = r_len;
        n_flags = r_flags;
        n_exact = r_exact;
        n_fq    = r_fq;
        n_fq_v  = r_fq_v;
        n_lq    = r_lq;
        n_lq_v  = r_lq_v;
        n_bank  = r_bank;
        n_iplen = r_iplen;
        n_head  = r_head;
        n_tail  = r_tail;
        n_wait  = r_wait;
        n_pop   = 1'b0;
        n_ipen  = 1'b0;
        n_acc   = 1'b0;
        n_drop  = 1'b0;
        cap_we  = 1'b0;
        cap_off = '0;
        push_we = 1'b0;
        ev      = at_rlc_pkg::EV_NONE;
        gap     = r_fq + LW'(1);
        q_len   = r_lq - gap;
        if (acc) begin
            unique case (at_rlc_pkg::t_opcode'(i_opcode))
                at_rlc_pkg::OP_CHAR: begin
                    if (i_char_byte != 8'd0 && r_len != LW'(at_rlc_pkg::LineMax - 1)) begin
                        n_win = {r_win[WinW-9:0], i_char_byte};
                        if (i_char_byte == at_rlc_pkg::CHR_QUOTE) begin
                            if (!r_fq_v) begin
                                n_fq   = r_len;
                                n_fq_v = 1'b1;
                            end
                            n_lq   = r_len;
                            n_lq_v = 1'b1;
                        end
                        if (r_fq_v && r_len > r_fq
                                && (r_len - gap) < LW'(at_rlc_pkg::IpMax)) begin
                            cap_we  = 1'b1;
                            cap_off = IW'(r_len - gap);
                        end
                        n_len = r_len + LW'(1);
                        if (n_win[87:0]   == at_rlc_pkg::PAT_GOT_IP)
                            n_flags[at_rlc_pkg::KW_GOT_IP]  = 1'b1;
                        if (n_win[39:0]   == at_rlc_pkg::PAT_ERROR)
                            n_flags[at_rlc_pkg::KW_ERROR]   = 1'b1;
                        if (n_win[31:0]   == at_rlc_pkg::PAT_FAIL)
                            n_flags[at_rlc_pkg::KW_FAIL]    = 1'b1;
                        if (n_win[119:0]  == at_rlc_pkg::PAT_DISCONN)
                            n_flags[at_rlc_pkg::KW_DISCONN] = 1'b1;
                        if (n_win[31:0]   == at_rlc_pkg::PAT_BUSY)
                            n_flags[at_rlc_pkg::KW_BUSY]    = 1'b1;
                        if (n_win[111:0]  == at_rlc_pkg::PAT_CONN_ED)
                            n_flags[at_rlc_pkg::KW_CONN_ED] = 1'b1;
                        if (n_win[95:0]   == at_rlc_pkg::PAT_CIFSR)
                            n_flags[at_rlc_pkg::KW_CIFSR]   = 1'b1;
                        if (n_win[47:0]   == at_rlc_pkg::PAT_CLOSED)
                            n_flags[at_rlc_pkg::KW_CLOSED]  = 1'b1;
                        if (n_win[7:0]    == at_rlc_pkg::PAT_PROMPT)
                            n_flags[at_rlc_pkg::KW_PROMPT]  = 1'b1;
                        if (n_win[55:0]   == at_rlc_pkg::PAT_SEND_OK)
                            n_flags[at_rlc_pkg::KW_SEND_OK] = 1'b1;
                        if (n_win[71:0]   == at_rlc_pkg::PAT_SEND_FL)
                            n_flags[at_rlc_pkg::KW_SEND_FL] = 1'b1;
                        n_exact[0] = (n_len == LW'(2)) && (n_win[15:0] == at_rlc_pkg::PAT_OK);
                        n_exact[1] = (n_len == LW'(7))
                                     && (n_win[55:0] == at_rlc_pkg::PAT_CONNECT);
                    end
                end
                at_rlc_pkg::OP_EOL: begin
                    if (r_flags[at_rlc_pkg::KW_GOT_IP]) begin
                        ev = at_rlc_pkg::EV_GOT_IP;
                    end else if (r_exact[0]) begin
                        ev     = at_rlc_pkg::EV_OK;
                        n_wait = 1'b0;
                    end else if (r_flags[at_rlc_pkg::KW_ERROR] || r_flags[at_rlc_pkg::KW_FAIL]) begin
                        ev     = at_rlc_pkg::EV_ERROR;
                        n_wait = 1'b0;
                    end else if (r_flags[at_rlc_pkg::KW_DISCONN]) begin
                        ev = at_rlc_pkg::EV_DISCONN;
                    end else if (r_flags[at_rlc_pkg::KW_BUSY]) begin
                        ev = at_rlc_pkg::EV_NONE;
                    end else if (r_flags[at_rlc_pkg::KW_CONN_ED]) begin
                        ev = at_rlc_pkg::EV_CONNECTED;
                    end else if (r_flags[at_rlc_pkg::KW_CIFSR]) begin
                        if (r_fq_v && r_lq_v && r_lq > r_fq
                                && q_len < LW'(at_rlc_pkg::IpMax)) begin
                            ev      = at_rlc_pkg::EV_IP_PARSED;
                            n_iplen = IW'(q_len);
                            n_bank  = !r_bank;
                        end
                    end else if (r_exact[1]) begin
                        ev = at_rlc_pkg::EV_TCP_CONN;
                    end else if (r_flags[at_rlc_pkg::KW_CLOSED]) begin
                        ev = at_rlc_pkg::EV_TCP_CLOSE;
                    end else if (r_flags[at_rlc_pkg::KW_PROMPT]) begin
                        ev = at_rlc_pkg::EV_PROMPT;
                    end else if (r_flags[at_rlc_pkg::KW_SEND_OK]) begin
                        ev = at_rlc_pkg::EV_SEND_OK;
                    end else if (r_flags[at_rlc_pkg::KW_SEND_FL]) begin
                        ev = at_rlc_pkg::EV_SEND_FAIL;
                    end
                    if (ev != at_rlc_pkg::EV_NONE) begin
                        if (r_head + QW'(1) == r_tail) begin
                            n_drop = 1'b1;
                        end else begin
                            push_we = 1'b1;
                            n_head  = r_head + QW'(1);
                        end
                    end
                    n_win   = '0;
                    n_len   = '0;
                    n_flags = '0;
                    n_exact = '0;
                    n_fq    = '0;
                    n_fq_v  = 1'b0;
                    n_lq    = '0;
                    n_lq_v  = 1'b0;
                end
                at_rlc_pkg::OP_POP: begin
                    if (r_tail != r_head) begin
                        n_pop  = 1'b1;
                        n_tail = r_tail + QW'(1);
                    end
                end
                at_rlc_pkg::OP_SEND: begin
                    if (!r_wait) begin
                        n_wait = 1'b1;
                        n_acc  = 1'b1;
                    end
                end
                at_rlc_pkg::OP_IPRD: begin
                    n_ipen = i_ip_index < r_iplen;
                end
                at_rlc_pkg::OP_CLEAR: begin
                    n_wait  = 1'b0;
                    n_head  = '0;
                    n_tail  = '0;
                    n_iplen = '0;
                end
                default: begin
                end
            endcase
        end
    end

    // memories: capture into the idle bank, read from the live one
    always_ff @(posedge i_clk) begin
        if (cap_we) begin
            r_ip_mem[{!r_bank, cap_off}] <= i_char_byte;
        end
        if (acc) begin
            r_ip_rd <= r_ip_mem[{r_bank, i_ip_index}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_we) begin
            r_ring[r_head] <= ev;
        end
        if (acc) begin
            r_ev_rd <= r_ring[r_tail];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win    <= '0;
            r_len    <= '0;
            r_flags  <= '0;
            r_exact  <= '0;
            r_fq     <= '0;
            r_fq_v   <= 1'b0;
            r_lq     <= '0;
            r_lq_v   <= 1'b0;
            r_bank   <= 1'b0;
            r_iplen  <= '0;
            r_head   <= '0;
            r_tail   <= '0;
            r_wait   <= 1'b0;
            r_s1_vld <= 1'b0;
            r_o_vld  <= 1'b0;
        end else begin
            r_win    <= n_win;
            r_len    <= n_len;
            r_flags  <= n_flags;
            r_exact  <= n_exact;
            r_fq     <= n_fq;
            r_fq_v   <= n_fq_v;
            r_lq     <= n_lq;
            r_lq_v   <= n_lq_v;
            r_bank   <= n_bank;
            r_iplen  <= n_iplen;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_wait   <= n_wait;
            if (adv) begin
                r_o_vld <= r_s1_vld;
            end
            if (acc) begin
                r_s1_vld <= 1'b1;
            end else if (adv) begin
                r_s1_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_pop   <= n_pop;
            r_s1_ipen  <= n_ipen;
            r_s1_acc   <= n_acc;
            r_s1_drop  <= n_drop;
            r_s1_wait  <= n_wait;
            r_s1_iplen <= n_iplen;
        end
        if (adv && r_s1_vld) begin
            r_o_ev    <= r_s1_pop ? r_ev_rd : at_rlc_pkg::EV_NONE;
            r_o_ipc   <= r_s1_ipen ? r_ip_rd : 8'd0;
            r_o_wait  <= r_s1_wait;
            r_o_acc   <= r_s1_acc;
            r_o_drop  <= r_s1_drop;
            r_o_iplen <= r_s1_iplen;
        end
    end

    assign o_valid         = r_o_vld;
    assign o_event_code    = r_o_ev;
    assign o_busy_res      = r_o_wait;
    assign o_send_accepted = r_o_acc;
    assign o_ip_char       = r_o_ipc;
    assign o_ip_length     = r_o_iplen;
    assign o_event_dropped = r_o_drop;

`ifndef ASSERT_OFF
    a_acc_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_send_accepted |-> o_busy_res)
        else $error("accepted send without busy");

    a_len_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LW'(at_rlc_pkg::LineMax - 1))
        else $error("line length overrun");

    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && n_drop |-> r_head + QW'(1) == r_tail && !push_we)
        else $error("drop with room in ring");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_vld && i_stall |=> r_o_vld && $stable(r_o_ev) && $stable(r_o_iplen))
        else $error("output changed under stall");
`endif

endmodule

FILE: test/at_response_line_classifier_chk.sv
// ----------------------------------------------------------------------------
// at_response_line_classifier_chk
// Watches both channels of the response line classifier, keeps its own model
// of the line matcher, event ring, IP store and busy flag, and compares each
// output beat field by field with the oldest predicted result.
// ----------------------------------------------------------------------------
module at_response_line_classifier_chk
    import at_rlc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic       o_stall,
    input  logic [2:0] i_opcode,
    input  logic [7:0] i_char_byte,
    input  logic [4:0] i_ip_index,
    input  logic       o_valid,
    input  logic       i_stall,
    input  logic [3:0] o_event_code,
    input  logic       o_busy_res,
    input  logic       o_send_accepted,
    input  logic [7:0] o_ip_char,
    input  logic [4:0] o_ip_length,
    input  logic       o_event_dropped,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_result_count,
    output int         o_drop_count,
    output int         o_parse_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [3:0] ev;
        logic       busy;
        logic       accepted;
        logic [7:0] ipc;
        logic [4:0] iplen;
        logic       dropped;
    } t_line_result;

    t_line_result   result_q[$];

    logic [119:0]   win;
    int             line_len;
    logic [10:0]    kw_flags;
    logic [1:0]     exact_hit;
    int             fq_pos, lq_pos;
    logic           fq_ok, lq_ok;
    logic [7:0]     capture[IpMax];
    logic [7:0]     ip_mem[IpMax];
    logic [4:0]     ip_len;
    logic [3:0]     ring[QueueDepth];
    int             head, tail;
    logic           busy;
    logic [119:0]   kw_pat[SubCount];
    int             kw_len[SubCount];
    int             fails, results, drops, parses;

    initial begin
        kw_pat[KW_GOT_IP]  = 120'(PAT_GOT_IP);  kw_len[KW_GOT_IP]  = 11;
        kw_pat[KW_ERROR]   = 120'(PAT_ERROR);   kw_len[KW_ERROR]   = 5;
        kw_pat[KW_FAIL]    = 120'(PAT_FAIL);    kw_len[KW_FAIL]    = 4;
        kw_pat[KW_DISCONN] = 120'(PAT_DISCONN); kw_len[KW_DISCONN] = 15;
        kw_pat[KW_BUSY]    = 120'(PAT_BUSY);    kw_len[KW_BUSY]    = 4;
        kw_pat[KW_CONN_ED] = 120'(PAT_CONN_ED); kw_len[KW_CONN_ED] = 14;
        kw_pat[KW_CIFSR]   = 120'(PAT_CIFSR);   kw_len[KW_CIFSR]   = 12;
        kw_pat[KW_CLOSED]  = 120'(PAT_CLOSED);  kw_len[KW_CLOSED]  = 6;
        kw_pat[KW_PROMPT]  = 120'(PAT_PROMPT);  kw_len[KW_PROMPT]  = 1;
        kw_pat[KW_SEND_OK] = 120'(PAT_SEND_OK); kw_len[KW_SEND_OK] = 7;
        kw_pat[KW_SEND_FL] = 120'(PAT_SEND_FL); kw_len[KW_SEND_FL] = 9;
    end

    function automatic logic tail_is(logic [119:0] w, logic [119:0] pat, int n);
        logic [119:0] m;
        m = (n >= WinLen) ? '1 : ((120'd1 << (8 * n)) - 120'd1);
        return (w & m) == pat;
    endfunction

    function automatic int ring_next(int p);
        return (p + 1 >= QueueDepth) ? 0 : p + 1;
    endfunction

    task automatic new_line();
        win = '0;
        line_len = 0;
        kw_flags = '0;
        exact_hit = '0;
        fq_pos = 0;
        lq_pos = 0;
        fq_ok = 1'b0;
        lq_ok = 1'b0;
    endtask

    task automatic take_char(logic [7:0] ch);
        int p;
        p = line_len;
        if (ch == 8'd0 || line_len >= LineMax - 1) return;
        win = {win[111:0], ch};
        if (ch == CHR_QUOTE) begin
            if (!fq_ok) begin
                fq_pos = p;
                fq_ok = 1'b1;
            end
            lq_pos = p;
            lq_ok = 1'b1;
        end
        if (fq_ok && p > fq_pos && p - fq_pos - 1 < IpMax)
            capture[p - fq_pos - 1] = ch;
        line_len = p + 1;
        for (int k = 0; k < SubCount; k++)
            if (tail_is(win, kw_pat[k], kw_len[k])) kw_flags[k] = 1'b1;
        exact_hit[0] = (line_len == 2) && tail_is(win, 120'(PAT_OK), 2);
        exact_hit[1] = (line_len == 7) && tail_is(win, 120'(PAT_CONNECT), 7);
    endtask

    function automatic t_event classify();
        int n;
        if (kw_flags[KW_GOT_IP]) return EV_GOT_IP;
        if (exact_hit[0]) begin
            busy = 1'b0;
            return EV_OK;
        end
        if (kw_flags[KW_ERROR] || kw_flags[KW_FAIL]) begin
            busy = 1'b0;
            return EV_ERROR;
        end
        if (kw_flags[KW_DISCONN]) return EV_DISCONN;
        if (kw_flags[KW_BUSY]) return EV_NONE;
        if (kw_flags[KW_CONN_ED]) return EV_CONNECTED;
        if (kw_flags[KW_CIFSR]) begin
            if (fq_ok && lq_ok && lq_pos > fq_pos) begin
                n = lq_pos - fq_pos - 1;
                if (n < IpMax) begin
                    for (int i = 0; i < n; i++) ip_mem[i] = capture[i];
                    ip_len = 5'(n);
                    parses++;
                    return EV_IP_PARSED;
                end
            end
            return EV_NONE;
        end
        if (exact_hit[1]) return EV_TCP_CONN;
        if (kw_flags[KW_CLOSED]) return EV_TCP_CLOSE;
        if (kw_flags[KW_PROMPT]) return EV_PROMPT;
        if (kw_flags[KW_SEND_OK]) return EV_SEND_OK;
        if (kw_flags[KW_SEND_FL]) return EV_SEND_FAIL;
        return EV_NONE;
    endfunction

    task automatic predict(logic [2:0] op, logic [7:0] ch, logic [4:0] idx);
        t_line_result r;
        t_event       ev;
        r = '0;
        case (op)
            OP_CHAR: take_char(ch);
            OP_EOL: begin
                ev = classify();
                if (ev != EV_NONE) begin
                    if (ring_next(head) == tail) begin
                        r.dropped = 1'b1;
                        drops++;
                    end else begin
                        ring[head] = ev;
                        head = ring_next(head);
                    end
                end
                new_line();
            end
            OP_POP: begin
                if (tail != head) begin
                    r.ev = ring[tail];
                    tail = ring_next(tail);
                end
            end
            OP_SEND: begin
                if (!busy) begin
                    busy = 1'b1;
                    r.accepted = 1'b1;
                end
            end
            OP_IPRD: begin
                if (idx < ip_len) r.ipc = ip_mem[idx];
            end
            OP_CLEAR: begin
                busy = 1'b0;
                head = 0;
                tail = 0;
                ip_len = '0;
            end
            default: ;
        endcase
        r.busy = busy;
        r.iplen = ip_len;
        result_q.push_back(r);
    endtask

    always @(posedge i_clk) begin
        t_line_result got, want;
        if (!i_rst_n) begin
            new_line();
            result_q.delete();
            ip_len = '0;
            head = 0;
            tail = 0;
            busy = 1'b0;
            fails = 0;
            results = 0;
            drops = 0;
            parses = 0;
        end else begin
            if (o_valid && !i_stall) begin
                got = {o_event_code, o_busy_res, o_send_accepted, o_ip_char,
                       o_ip_length, o_event_dropped};
                results++;
                if (result_q.size() == 0) begin
                    $display("%0t: unexpected beat ev=%0d busy=%0b acc=%0b ipc=%h len=%0d drop=%0b",
                             $realtime, got.ev, got.busy, got.accepted, got.ipc, got.iplen,
                             got.dropped);
                    fails++;
                end else begin
                    want = result_q.pop_front();
                    if (got !== want) begin
                        $display("%0t: mismatch expected ev=%0d busy=%0b acc=%0b ipc=%h len=%0d drop=%0b, actual ev=%0d busy=%0b acc=%0b ipc=%h len=%0d drop=%0b",
                                 $realtime, want.ev, want.busy, want.accepted, want.ipc,
                                 want.iplen, want.dropped, got.ev, got.busy, got.accepted,
                                 got.ipc, got.iplen, got.dropped);
                        fails++;
                    end
                end
            end
            if (i_valid && !o_stall) predict(i_opcode, i_char_byte, i_ip_index);
        end
        o_fail_count   <= fails;
        o_pending      <= result_q.size();
        o_result_count <= results;
        o_drop_count   <= drops;
        o_parse_count  <= parses;
    end

endmodule

FILE: test/at_response_line_classifier_tb.sv
// ----------------------------------------------------------------------------
// at_response_line_classifier_tb
// Drives response text, end of line, pop, send, IP read and clear beats into
// the classifier: a directed pass over every keyword and corner, then random
// lines and commands under four idling and stalling phases.
// ----------------------------------------------------------------------------
module at_response_line_classifier_tb;
    import at_rlc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] OP_SPARE_A = 3'd6;
    localparam logic [2:0] OP_SPARE_B = 3'd7;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic [2:0] i_opcode;
    logic [7:0] i_char_byte;
    logic [4:0] i_ip_index;
    logic       o_valid;
    logic       i_stall;
    logic [3:0] o_event_code;
    logic       o_busy_res;
    logic       o_send_accepted;
    logic [7:0] o_ip_char;
    logic [4:0] o_ip_length;
    logic       o_event_dropped;
    int         fail_count, pending, result_count, drop_count, parse_count;
    int         idle_pct, stall_pct;

    at_response_line_classifier dut (.*);

    at_response_line_classifier_chk chk (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_opcode, .i_char_byte, .i_ip_index,
        .o_valid, .i_stall, .o_event_code, .o_busy_res, .o_send_accepted, .o_ip_char,
        .o_ip_length, .o_event_dropped,
        .o_fail_count(fail_count), .o_pending(pending), .o_result_count(result_count),
        .o_drop_count(drop_count), .o_parse_count(parse_count)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    initial begin
        #5_000_000;
        $display("FAIL at_response_line_classifier");
        $finish;
    end

    task automatic beat(logic [2:0] op, logic [7:0] ch);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_opcode    <= op;
        i_char_byte <= ch;
        i_ip_index  <= 5'($urandom);
        @(negedge i_clk);
        while (o_stall) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic ip_read(logic [4:0] idx);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_opcode    <= OP_IPRD;
        i_char_byte <= 8'($urandom);
        i_ip_index  <= idx;
        @(negedge i_clk);
        while (o_stall) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic send_line(string s, bit with_zero);
        for (int i = 0; i < s.len(); i++) begin
            if (with_zero && $urandom_range(9) == 0) beat(OP_CHAR, 8'd0);
            beat(OP_CHAR, s[i]);
        end
        beat(OP_EOL, 8'($urandom));
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    function automatic string noise(int n);
        string s;
        s = "";
        for (int i = 0; i < n; i++) begin
            s = {s, " "};
            s[s.len() - 1] = 8'($urandom_range(1, 255));
        end
        return s;
    endfunction

    function automatic string ip_text(int n);
        string s;
        s = "";
        for (int i = 0; i < n; i++) begin
            s = {s, " "};
            s[s.len() - 1] = ($urandom_range(3) == 0) ? "." : 8'($urandom_range(48, 57));
        end
        return s;
    endfunction

    function automatic string pick_line();
        string s;
        case ($urandom_range(15))
            0:  s = "WIFI GOT IP";
            1:  s = "OK";
            2:  s = "ERROR";
            3:  s = "SEND FAIL";
            4:  s = "WIFI DISCONNECT";
            5:  s = "busy p...";
            6:  s = "WIFI CONNECTED";
            7, 8: s = {"+CIFSR:STAIP,\"",
                       ip_text(($urandom_range(7) == 0) ? $urandom_range(28, 36)
                                                          : $urandom_range(0, 15)),
                       "\""};
            9:  s = "CONNECT";
            10: s = "0,CLOSED";
            11: s = ">";
            12: s = "SEND OK";
            13: s = "FAIL";
            14: s = noise($urandom_range(0, 20));
            default: s = "+CIFSR:STAIP\"";
        endcase
        if ($urandom_range(4) == 0) s = {noise($urandom_range(1, 4)), s};
        if ($urandom_range(4) == 0) s = {s, noise($urandom_range(1, 4))};
        if ($urandom_range(40) == 0) s = {noise(135), s};
        return s;
    endfunction

    initial begin
        string long_ok;
        int    ops;
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_opcode    <= OP_CHAR;
        i_char_byte <= 8'd0;
        i_ip_index  <= 5'd0;
        i_stall     <= 1'b0;
        idle_pct  = 0;
        stall_pct = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        beat(OP_POP, 8'd0);
        beat(OP_SEND, 8'hff);
        beat(OP_SEND, 8'h00);
        send_line("OK", 1'b1);
        send_line("ERROR", 1'b0);
        send_line("WIFI GOT IP", 1'b0);
        send_line("WIFI DISCONNECT", 1'b0);
        send_line("busy p...", 1'b0);
        send_line("WIFI CONNECTED", 1'b0);
        send_line("+CIFSR:STAIP,\"192.168.4.21\"", 1'b1);
        send_line("CONNECT", 1'b0);
        send_line("CLOSED", 1'b0);
        send_line(">", 1'b0);
        send_line("SEND OK", 1'b0);
        repeat (8) beat(OP_POP, 8'd0);
        send_line("SEND FAIL", 1'b0);
        ip_read(5'd0);
        ip_read(5'd31);
        send_line({"+CIFSR:STAIP,\"", ip_text(32), "\""}, 1'b0);
        long_ok = {noise(126), "OK"};
        send_line(long_ok, 1'b0);
        beat(OP_SPARE_A, 8'h55);
        beat(OP_SPARE_B, 8'haa);
        beat(OP_CLEAR, 8'd0);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            idle_pct  = (ph == 1) ? 75 : (ph == 3) ? 38 : 0;
            stall_pct = (ph == 2) ? 75 : (ph == 3) ? 38 : 0;
            for (ops = 0; ops < 8; ops++) begin
                case ($urandom_range(19))
                    0, 1, 2, 3, 4, 5, 6, 7, 8: send_line(pick_line(), $urandom_range(1));
                    9, 10, 11: beat(OP_POP, 8'($urandom));
                    12, 13: beat(OP_SEND, 8'($urandom));
                    14, 15: ip_read(5'($urandom));
                    16: beat(OP_CLEAR, 8'($urandom));
                    17: beat($urandom_range(1) ? OP_SPARE_A : OP_SPARE_B, 8'($urandom));
                    default: beat(OP_CHAR, 8'($urandom));
                endcase
            end
            if (ph == 1) drain();
        end

        i_valid <= 1'b0;
        @(posedge i_clk);
        for (int n = 0; pending != 0; n++) begin
            if (n > 100000) begin
                $display("FAIL at_response_line_classifier");
                $finish;
            end
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
        $display("Checked %0d result beats: %0d IP addresses parsed, %0d events dropped.",
                 result_count, parse_count, drop_count);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS at_response_line_classifier");
        end else begin
            $display("FAIL at_response_line_classifier");
        end
        $finish;
    end

endmodule

FILE: at_response_line_classifier.f
hw/rtl/at_rlc_pkg.sv
hw/rtl/at_response_line_classifier.sv
test/at_response_line_classifier_chk.sv
test/at_response_line_classifier_tb.sv
